// File: design/tqrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqrq_pkg: shared types and constants
// Sizes, codes, payload structs and small helpers for the three-queue
// rotating-quantum scheduler.
// ----------------------------------------------------------------------------
package tqrq_pkg;

	localparam int MAX_JOBS    = 32;
	localparam int WORK_BITS   = 16;
	localparam int NQ          = 3;

	localparam int IN_WORK_W   = 16;
	localparam int QUANT_W     = 16;
	localparam int JOBNUM_W    = 6;
	localparam int QI_W        = 2;
	localparam int JOB_W       = $clog2(MAX_JOBS);
	localparam int CNT_W       = $clog2(MAX_JOBS + 1);
	localparam int STORE_DEPTH = NQ * MAX_JOBS;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int SUB_W       = (WORK_BITS > QUANT_W) ? WORK_BITS : QUANT_W;

	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [QI_W-1:0] LAST_Q = QI_W'(NQ - 1);

	// op codes
	localparam logic [1:0] OP_ARRIVE = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_DUMP   = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_ENTRY = 2'd2;
	localparam logic [1:0] KIND_EMPTY = 2'd3;

	// register indexes
	localparam logic [1:0] REG_Q0 = 2'd0;
	localparam logic [1:0] REG_Q1 = 2'd1;
	localparam logic [1:0] REG_Q2 = 2'd2;

	typedef struct packed {
		logic [1:0]           op;
		logic [IN_WORK_W-1:0] work_amount;
	} item_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [QI_W-1:0]     queue_index;
		logic [JOBNUM_W-1:0] job_number;
		logic                queue_end;
		logic                rejected;
		logic [1:0]          finished_count;
		logic                last;
	} result_t;

	typedef logic [NQ-1:0][QUANT_W-1:0] quanta_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARRIVE,
		ST_TK_POP,
		ST_TK_JOB,
		ST_TK_SUB,
		ST_TK_PUSH,
		ST_TK_DONE,
		ST_DP_START,
		ST_DP_RD,
		ST_DP_EMIT,
		ST_DP_EMPTY
	} state_t;

	function automatic logic [JOB_W-1:0] pos_inc(input logic [JOB_W-1:0] pos);
		return (pos == JOB_W'(MAX_JOBS - 1)) ? '0 : pos + 1'b1;
	endfunction

	function automatic logic [QI_W-1:0] q_next(input logic [QI_W-1:0] q);
		return (q == LAST_Q) ? '0 : q + 1'b1;
	endfunction

	function automatic logic [QI_W-1:0] q_prev(input logic [QI_W-1:0] q);
		return (q == '0) ? LAST_Q : q - 1'b1;
	endfunction

	function automatic logic [STORE_AW-1:0] store_addr(input logic [QI_W-1:0] q,
			input logic [JOB_W-1:0] pos);
		return STORE_AW'(int'(q) * MAX_JOBS + int'(pos));
	endfunction

	// clamp arriving work to the work counter range
	function automatic logic [WORK_BITS-1:0] sat_work(input logic [IN_WORK_W-1:0] w);
		logic [WORK_BITS+IN_WORK_W-1:0] wide;
		logic [WORK_BITS-1:0]           wmax;
		wmax = '1;
		wide = (WORK_BITS + IN_WORK_W)'(w);
		if (wide > (WORK_BITS + IN_WORK_W)'(wmax))
			return wmax;
		return wide[WORK_BITS-1:0];
	endfunction

endpackage

// File: design/tqrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqrq_ram: simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module tqrq_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/tqrq_satsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqrq_satsub: saturating work subtractor
// Takes a quantum off a work count, clamping at zero; shared by all queues.
// ----------------------------------------------------------------------------
module tqrq_satsub
	import tqrq_pkg::*;
(
	input  logic [WORK_BITS-1:0] work,
	input  logic [QUANT_W-1:0]   quantum,
	output logic [WORK_BITS-1:0] diff,
	output logic                 zero
);

	logic [SUB_W-1:0] w_ext;
	logic [SUB_W-1:0] q_ext;
	logic [SUB_W-1:0] d_ext;

	assign w_ext = SUB_W'(work);
	assign q_ext = SUB_W'(quantum);
	assign d_ext = (w_ext > q_ext) ? (w_ext - q_ext) : '0;
	assign diff  = d_ext[WORK_BITS-1:0];
	assign zero  = (d_ext == '0);

endmodule

// File: design/tqrq_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqrq_regs: configuration registers
// APB-style access to the three per-queue quanta.
// ----------------------------------------------------------------------------
module tqrq_regs
	import tqrq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output quanta_t           quanta
);

	quanta_t    quanta_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quanta_q <= {NQ{QUANT_W'(1)}};
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_Q0:  quanta_q[0] <= pwdata[QUANT_W-1:0];
				REG_Q1:  quanta_q[1] <= pwdata[QUANT_W-1:0];
				REG_Q2:  quanta_q[2] <= pwdata[QUANT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_Q0:  prdata = DATA_W'(quanta_q[0]);
			REG_Q1:  prdata = DATA_W'(quanta_q[1]);
			REG_Q2:  prdata = DATA_W'(quanta_q[2]);
			default: prdata = '0;
		endcase
	end

	assign quanta = quanta_q;

endmodule

// File: design/three_queue_rotating_quantum_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_queue_rotating_quantum_scheduler: top level and sequencer
// Arrive: ARRIVE registers the result. Tick: store read, work read, subtract
// steps per non-empty queue, a skip step per empty queue, 3 push steps, then
// a step to register the result. Dump: a start step per queue, then read and
// emit steps per listed entry or an empty marker. Result steps wait out a
// stall. One item in flight; the next transfer is taken once its last result
// is registered. Reset clears control and sets quanta to 1; RAMs kept.
// ----------------------------------------------------------------------------
module three_queue_rotating_quantum_scheduler
	import tqrq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	quanta_t quanta;

	state_t                       state_q, state_d;
	logic [QI_W-1:0]              qi_q, qi_d;
	logic [CNT_W-1:0]             next_job_q, next_job_d;
	logic [NQ-1:0][JOB_W-1:0]     head_q, head_d;
	logic [NQ-1:0][JOB_W-1:0]     tail_q, tail_d;
	logic [NQ-1:0][CNT_W-1:0]     count_q, count_d;
	logic [NQ-1:0]                moving_q, moving_d;
	logic [1:0]                   fin_q, fin_d;
	logic                         out_valid_q, out_valid_d;

	logic [IN_WORK_W-1:0]         work_q, work_d;
	logic [NQ-1:0][JOB_W-1:0]     job_q, job_d;
	logic [JOB_W-1:0]             pos_q, pos_d;
	logic [CNT_W-1:0]             left_q, left_d;
	result_t                      out_q, out_d;

	logic                         st_we, st_re;
	logic [STORE_AW-1:0]          st_waddr, st_raddr;
	logic [JOB_W-1:0]             st_wdata, st_rdata;
	logic                         wk_we, wk_re;
	logic [JOB_W-1:0]             wk_waddr, wk_raddr;
	logic [WORK_BITS-1:0]         wk_wdata, wk_rdata;

	logic [WORK_BITS-1:0]         su_diff;
	logic                         su_zero;

	logic                         out_free;
	logic                         res_load;
	result_t                      res;
	logic [QI_W-1:0]              src_q;

	tqrq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.quanta  (quanta)
	);

	tqrq_ram #(.DEPTH(STORE_DEPTH), .WIDTH(JOB_W)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	tqrq_ram #(.DEPTH(MAX_JOBS), .WIDTH(WORK_BITS)) u_work (
		.clk   (clk),
		.we    (wk_we),
		.waddr (wk_waddr),
		.wdata (wk_wdata),
		.re    (wk_re),
		.raddr (wk_raddr),
		.rdata (wk_rdata)
	);

	tqrq_satsub u_sub (
		.work    (wk_rdata),
		.quantum (quanta[qi_q]),
		.diff    (su_diff),
		.zero    (su_zero)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_free     = !out_valid_q || !result_stall;
	assign src_q        = q_prev(qi_q);

	always_comb begin
		state_d    = state_q;
		qi_d       = qi_q;
		next_job_d = next_job_q;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		moving_d   = moving_q;
		fin_d      = fin_q;
		work_d     = work_q;
		job_d      = job_q;
		pos_d      = pos_q;
		left_d     = left_q;

		st_we      = 1'b0;
		st_waddr   = '0;
		st_wdata   = '0;
		st_re      = 1'b0;
		st_raddr   = '0;
		wk_we      = 1'b0;
		wk_waddr   = '0;
		wk_wdata   = '0;
		wk_re      = 1'b0;
		wk_raddr   = '0;

		res_load   = 1'b0;
		res        = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					work_d = item.work_amount;
					qi_d   = '0;
					fin_d  = '0;
					case (item.op)
						OP_ARRIVE: state_d = ST_ARRIVE;
						OP_TICK:   state_d = ST_TK_POP;
						OP_DUMP:   state_d = ST_DP_START;
						default:   state_d = ST_IDLE;
					endcase
				end
			end

			ST_ARRIVE: begin
				if (out_free) begin
					res_load = 1'b1;
					res.kind = KIND_ACK;
					res.last = 1'b1;
					if (next_job_q == CNT_W'(MAX_JOBS)) begin
						res.rejected = 1'b1;
					end else begin
						wk_we          = 1'b1;
						wk_waddr       = next_job_q[JOB_W-1:0];
						wk_wdata       = sat_work(work_q);
						st_we          = 1'b1;
						st_waddr       = store_addr('0, tail_q[0]);
						st_wdata       = next_job_q[JOB_W-1:0];
						tail_d[0]      = pos_inc(tail_q[0]);
						count_d[0]     = count_q[0] + 1'b1;
						next_job_d     = next_job_q + 1'b1;
						res.job_number = JOBNUM_W'(next_job_q) + 1'b1;
					end
					state_d = ST_IDLE;
				end
			end

			ST_TK_POP: begin
				if (count_q[qi_q] != '0) begin
					st_re         = 1'b1;
					st_raddr      = store_addr(qi_q, head_q[qi_q]);
					head_d[qi_q]  = pos_inc(head_q[qi_q]);
					count_d[qi_q] = count_q[qi_q] - 1'b1;
					state_d       = ST_TK_JOB;
				end else begin
					moving_d[qi_q] = 1'b0;
					qi_d           = q_next(qi_q);
					if (qi_q == LAST_Q)
						state_d = ST_TK_PUSH;
				end
			end

			ST_TK_JOB: begin
				wk_re       = 1'b1;
				wk_raddr    = st_rdata;
				job_d[qi_q] = st_rdata;
				state_d     = ST_TK_SUB;
			end

			ST_TK_SUB: begin
				wk_we          = 1'b1;
				wk_waddr       = job_q[qi_q];
				wk_wdata       = su_diff;
				moving_d[qi_q] = !su_zero;
				fin_d          = fin_q + 2'(su_zero);
				qi_d           = q_next(qi_q);
				state_d        = (qi_q == LAST_Q) ? ST_TK_PUSH : ST_TK_POP;
			end

			// qi is the receiving queue, src the one it is fed from
			ST_TK_PUSH: begin
				if (moving_q[src_q]) begin
					st_we         = 1'b1;
					st_waddr      = store_addr(qi_q, tail_q[qi_q]);
					st_wdata      = job_q[src_q];
					tail_d[qi_q]  = pos_inc(tail_q[qi_q]);
					count_d[qi_q] = count_q[qi_q] + 1'b1;
				end
				qi_d = q_next(qi_q);
				if (qi_q == LAST_Q)
					state_d = ST_TK_DONE;
			end

			ST_TK_DONE: begin
				if (out_free) begin
					res_load           = 1'b1;
					res.kind           = KIND_TICK;
					res.finished_count = fin_q;
					res.last           = 1'b1;
					state_d            = ST_IDLE;
				end
			end

			ST_DP_START: begin
				pos_d   = head_q[qi_q];
				left_d  = count_q[qi_q];
				state_d = (count_q[qi_q] == '0) ? ST_DP_EMPTY : ST_DP_RD;
			end

			ST_DP_EMPTY: begin
				if (out_free) begin
					res_load        = 1'b1;
					res.kind        = KIND_EMPTY;
					res.queue_index = qi_q;
					res.queue_end   = 1'b1;
					res.last        = (qi_q == LAST_Q);
					qi_d            = q_next(qi_q);
					state_d         = (qi_q == LAST_Q) ? ST_IDLE : ST_DP_START;
				end
			end

			ST_DP_RD: begin
				st_re    = 1'b1;
				st_raddr = store_addr(qi_q, pos_q);
				pos_d    = pos_inc(pos_q);
				state_d  = ST_DP_EMIT;
			end

			ST_DP_EMIT: begin
				if (out_free) begin
					res_load        = 1'b1;
					res.kind        = KIND_ENTRY;
					res.queue_index = qi_q;
					res.job_number  = JOBNUM_W'(st_rdata) + 1'b1;
					res.queue_end   = (left_q == CNT_W'(1));
					res.last        = (left_q == CNT_W'(1)) && (qi_q == LAST_Q);
					left_d          = left_q - 1'b1;
					if (left_q == CNT_W'(1)) begin
						qi_d    = q_next(qi_q);
						state_d = (qi_q == LAST_Q) ? ST_IDLE : ST_DP_START;
					end else begin
						state_d = ST_DP_RD;
					end
				end
			end

			default: state_d = ST_IDLE;
		endcase

		if (res_load) begin
			out_valid_d = 1'b1;
			out_d       = res;
		end else begin
			out_valid_d = out_valid_q && result_stall;
			out_d       = out_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			qi_q        <= '0;
			next_job_q  <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			moving_q    <= '0;
			fin_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			qi_q        <= qi_d;
			next_job_q  <= next_job_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			moving_q    <= moving_d;
			fin_q       <= fin_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		work_q <= work_d;
		job_q  <= job_d;
		pos_q  <= pos_d;
		left_q <= left_d;
		out_q  <= out_d;
	end

endmodule

// File: design/tqrq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqrq_checker: port-level checks
// Watches the item and result channels of the scheduler top level.
// ----------------------------------------------------------------------------
module tqrq_checker
	import tqrq_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// any real op makes the block busy in the next cycle
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op != OP_NONE |=> item_stall)
		else $error("item taken without going busy");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_EMPTY |->
			result.queue_end && result.job_number == '0 &&
			result.last == (result.queue_index == LAST_Q))
		else $error("malformed empty marker");

	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.rejected |->
			result.kind == KIND_ACK && result.last && result.job_number == '0)
		else $error("malformed reject");

endmodule

bind three_queue_rotating_quantum_scheduler tqrq_checker u_tqrq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
